[rtl/core/bucketed_priority_queue_top_assert.svh]
// Assertion macros for the bucketed priority queue.
// Included by bucketed_priority_queue_top, which checks its own logic; depends on nothing.
`ifndef BUCKETED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BUCKETED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bpq_pkg.sv]
// Shared types and constants of the bucketed priority queue.
// Used by every module of the block but bpq_ram; depends on nothing.
package bpq_pkg;

  localparam int NUM_LEVELS_DEF  = 16;
  localparam int CAPACITY_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int ELEMENT_W     = 32;
  localparam int LEVEL_FIELD_W = 4;
  localparam int STATUS_W      = 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FULL  = 2'd2,
    OP_EMPTY = 2'd3
  } op_kind_t;

  typedef struct packed {
    logic                        command;
    logic signed [ELEMENT_W-1:0] element;
    logic [LEVEL_FIELD_W-1:0]    priority_req;
  } bpq_cmd_t;

  typedef struct packed {
    logic signed [ELEMENT_W-1:0] popped_value;
    logic [LEVEL_FIELD_W-1:0]    popped_level;
    logic [STATUS_W-1:0]         status;
    logic                        queue_empty;
  } bpq_res_t;

  // Access controls for the level table.
  typedef struct packed {
    logic rd;
    logic wr;
    logic occ_set;
    logic occ_clr;
  } bpq_lvl_op_t;

  // Access controls for the entry store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic alloc;
  } bpq_ent_op_t;

endpackage

[rtl/core/bpq_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; read data holds until the next read.
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/bpq_level_table.sv]
// Per-level head pointer and element count, held in one RAM, plus the
// occupancy flags and the lowest-occupied-level search. Depends on bpq_pkg, bpq_ram.
module bpq_level_table #(
  parameter int NUM_LEVELS = bpq_pkg::NUM_LEVELS_DEF,
  parameter int CAPACITY   = bpq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bpq_pkg::bpq_lvl_op_t          op,
  input  logic [$clog2(NUM_LEVELS)-1:0] addr,
  input  logic [$clog2(CAPACITY)-1:0]   wr_head,
  input  logic [$clog2(CAPACITY+1)-1:0] wr_count,
  output logic [$clog2(CAPACITY)-1:0]   rd_head,
  output logic [$clog2(CAPACITY+1)-1:0] rd_count,
  output logic                          any_occupied,
  output logic [$clog2(NUM_LEVELS)-1:0] first_level
);
  import bpq_pkg::*;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY+1);

  logic [NUM_LEVELS-1:0]   occupied;
  logic                    rd_valid;
  logic [ADDR_W+CNT_W-1:0] ram_rd_data;

  bpq_ram #(
    .WIDTH (ADDR_W + CNT_W),
    .DEPTH (NUM_LEVELS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (op.wr),
    .wr_addr (addr),
    .wr_data ({wr_head, wr_count}),
    .rd_en   (op.rd),
    .rd_addr (addr),
    .rd_data (ram_rd_data)
  );

  // The occupancy flag doubles as the valid bit of a level's RAM row: an
  // unoccupied level reads as count zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else if (op.wr) begin
      if (op.occ_set) begin
        occupied[addr] <= 1'b1;
      end else if (op.occ_clr) begin
        occupied[addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.rd) begin
      rd_valid <= occupied[addr];
    end
  end

  assign rd_head      = ram_rd_data[ADDR_W+CNT_W-1:CNT_W];
  assign rd_count     = rd_valid ? ram_rd_data[CNT_W-1:0] : '0;
  assign any_occupied = |occupied;

  always_comb begin
    first_level = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (occupied[i]) begin
        first_level = LVL_W'(i);
      end
    end
  end

endmodule

[rtl/core/bpq_entry_store.sv]
// Element values and next links of all entries, held in one RAM, with the
// fill count that stands in for the initial free chain. Depends on bpq_pkg, bpq_ram.
module bpq_entry_store #(
  parameter int CAPACITY    = bpq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bpq_pkg::bpq_ent_op_t        op,
  input  logic [$clog2(CAPACITY)-1:0] addr,
  input  logic [VALUE_WIDTH-1:0]      wr_value,
  input  logic [$clog2(CAPACITY)-1:0] wr_link,
  output logic [VALUE_WIDTH-1:0]      rd_value,
  output logic [$clog2(CAPACITY)-1:0] rd_link
);
  import bpq_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY+1);

  logic [CNT_W-1:0]              fresh;
  logic                          rd_fresh;
  logic [ADDR_W-1:0]             rd_addr_q;
  logic [VALUE_WIDTH+ADDR_W-1:0] ram_rd_data;

  bpq_ram #(
    .WIDTH (VALUE_WIDTH + ADDR_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (op.wr),
    .wr_addr (addr),
    .wr_data ({wr_value, wr_link}),
    .rd_en   (op.rd),
    .rd_addr (addr),
    .rd_data (ram_rd_data)
  );

  // Entries leave the untouched part of the free chain in ascending order,
  // so exactly the entries below the fill count have ever been written.
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= '0;
    end else if (op.wr && op.alloc && (CNT_W'(addr) == fresh)) begin
      fresh <= fresh + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (op.rd) begin
      rd_fresh  <= (CNT_W'(addr) >= fresh);
      rd_addr_q <= addr;
    end
  end

  assign rd_value = ram_rd_data[VALUE_WIDTH+ADDR_W-1:ADDR_W];

  // An unwritten entry still links to its successor, wrapping at the end.
  always_comb begin
    if (!rd_fresh) begin
      rd_link = ram_rd_data[ADDR_W-1:0];
    end else if (rd_addr_q == ADDR_W'(CAPACITY - 1)) begin
      rd_link = '0;
    end else begin
      rd_link = rd_addr_q + ADDR_W'(1);
    end
  end

endmodule

[rtl/core/bucketed_priority_queue_top.sv]
// Channel   Handshake              Payload             Moves
// cmd       cmd_valid/cmd_ready    cmd_data (cmd_t)    one push or pop request
// res       res_valid/res_ready    res_data (res_t)    one result per request
//
// A push reads the level table and the entry store, then writes back; a pop
// reads the level table, then the entry whose address that read gives, then
// writes back. A push on a full queue or a pop on an empty one reads neither
// RAM. The level-table and entry RAMs take one read each per step. A new
// request is taken while the previous result waits in the output register;
// write-back stalls only while that register is still held. Reset needs no
// clearing pass: a fill count covers the never-used entries.
// Depends on bpq_pkg, bpq_level_table, bpq_entry_store and the assert header.
`include "bucketed_priority_queue_top_assert.svh"

module bucketed_priority_queue_top #(
  parameter int NUM_LEVELS  = bpq_pkg::NUM_LEVELS_DEF,
  parameter int CAPACITY    = bpq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  bpq_pkg::bpq_cmd_t cmd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output bpq_pkg::bpq_res_t res_data
);
  import bpq_pkg::*;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY+1);

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_POP_HEAD = 3'b010,
    S_COMMIT   = 3'b100
  } state_t;

  state_t               state, state_next;
  op_kind_t             op_kind;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [LVL_W-1:0]     lvl_q;
  logic [ADDR_W-1:0]    free_head;
  logic [CNT_W-1:0]     used;
  bpq_res_t             res_q, res_next;

  bpq_lvl_op_t          lvl_op;
  logic [LVL_W-1:0]     lvl_addr;
  logic [ADDR_W-1:0]    lvl_wr_head;
  logic [CNT_W-1:0]     lvl_wr_count;
  logic [ADDR_W-1:0]    lvl_rd_head;
  logic [CNT_W-1:0]     lvl_rd_count;
  logic                 lvl_any;
  logic [LVL_W-1:0]     lvl_first;

  bpq_ent_op_t          ent_op;
  logic [ADDR_W-1:0]    ent_addr;
  logic [VALUE_WIDTH-1:0] ent_wr_value;
  logic [ADDR_W-1:0]    ent_wr_link;
  logic [VALUE_WIDTH-1:0] ent_rd_value;
  logic [ADDR_W-1:0]    ent_rd_link;

  logic                 accept;
  logic                 is_push;
  logic                 is_full;
  logic                 is_empty;
  logic                 fire;
  logic [LVL_W-1:0]     lvl_sat;

  bpq_level_table #(
    .NUM_LEVELS (NUM_LEVELS),
    .CAPACITY   (CAPACITY)
  ) u_levels (
    .clk          (clk),
    .rst          (rst),
    .op           (lvl_op),
    .addr         (lvl_addr),
    .wr_head      (lvl_wr_head),
    .wr_count     (lvl_wr_count),
    .rd_head      (lvl_rd_head),
    .rd_count     (lvl_rd_count),
    .any_occupied (lvl_any),
    .first_level  (lvl_first)
  );

  bpq_entry_store #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_entries (
    .clk      (clk),
    .rst      (rst),
    .op       (ent_op),
    .addr     (ent_addr),
    .wr_value (ent_wr_value),
    .wr_link  (ent_wr_link),
    .rd_value (ent_rd_value),
    .rd_link  (ent_rd_link)
  );

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign is_push   = (cmd_data.command == CMD_PUSH);
  assign is_full   = (used >= CNT_W'(CAPACITY));
  assign is_empty  = (used == '0) || !lvl_any;
  assign fire      = (state == S_COMMIT) && (!res_valid || res_ready);

  // Levels past the last one are folded onto the last level.
  assign lvl_sat = (int'(cmd_data.priority_req) >= NUM_LEVELS) ?
                   LVL_W'(NUM_LEVELS - 1) : LVL_W'(cmd_data.priority_req);

  always_comb begin
    state_next   = state;
    lvl_op       = '0;
    ent_op       = '0;
    lvl_addr     = lvl_q;
    lvl_wr_head  = free_head;
    lvl_wr_count = lvl_rd_count + CNT_W'(1);
    ent_addr     = free_head;
    ent_wr_value = value_q;
    ent_wr_link  = lvl_rd_head;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_COMMIT;
          if (is_push) begin
            lvl_addr = lvl_sat;
            if (!is_full) begin
              lvl_op.rd = 1'b1;
              ent_op.rd = 1'b1;
            end
          end else begin
            lvl_addr = lvl_first;
            if (!is_empty) begin
              lvl_op.rd  = 1'b1;
              state_next = S_POP_HEAD;
            end
          end
        end
      end
      S_POP_HEAD: begin
        ent_addr   = lvl_rd_head;
        ent_op.rd  = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (op_kind == OP_POP) begin
          ent_addr = lvl_rd_head;
        end
        if (fire) begin
          state_next = S_IDLE;
          unique case (op_kind)
            OP_PUSH: begin
              ent_op.wr      = 1'b1;
              ent_op.alloc   = 1'b1;
              lvl_op.wr      = 1'b1;
              lvl_op.occ_set = 1'b1;
            end
            OP_POP: begin
              // The popped entry goes back on the front of the free list.
              ent_wr_value   = ent_rd_value;
              ent_wr_link    = free_head;
              ent_op.wr      = 1'b1;
              lvl_wr_head    = ent_rd_link;
              lvl_wr_count   = lvl_rd_count - CNT_W'(1);
              lvl_op.wr      = 1'b1;
              lvl_op.occ_clr = (lvl_rd_count == CNT_W'(1));
            end
            OP_FULL, OP_EMPTY: begin
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_next              = '0;
    res_next.status       = ST_OK;
    res_next.queue_empty  = (used == '0);
    unique case (op_kind)
      OP_PUSH: begin
        res_next.queue_empty = 1'b0;
      end
      OP_POP: begin
        res_next.popped_value = ELEMENT_W'(ent_rd_value);
        res_next.popped_level = LEVEL_FIELD_W'(lvl_q);
        res_next.queue_empty  = (used == CNT_W'(1));
      end
      OP_FULL: begin
        res_next.status = ST_PUSH_FULL;
      end
      OP_EMPTY: begin
        res_next.status = ST_POP_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        res_valid <= 1'b1;
        unique case (op_kind)
          OP_PUSH: begin
            free_head <= ent_rd_link;
            used      <= used + CNT_W'(1);
          end
          OP_POP: begin
            free_head <= lvl_rd_head;
            used      <= used - CNT_W'(1);
          end
          OP_FULL, OP_EMPTY: begin
          end
        endcase
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_q <= VALUE_WIDTH'($unsigned(cmd_data.element));
      if (is_push) begin
        lvl_q   <= lvl_sat;
        op_kind <= is_full ? OP_FULL : OP_PUSH;
      end else begin
        lvl_q   <= lvl_first;
        op_kind <= is_empty ? OP_EMPTY : OP_POP;
      end
    end
    if (fire) begin
      res_q <= res_next;
    end
  end

  assign res_data = res_q;

  `BPQ_ASSERT_NOW(a_used_bound, clk, rst, 1'b1, used <= CNT_W'(CAPACITY),
                  "element count exceeds capacity")
  `BPQ_ASSERT_NOW(a_empty_match, clk, rst, 1'b1, (used == '0) == !lvl_any,
                  "element count and level occupancy disagree")
  `BPQ_ASSERT_NEXT(a_commit_hold, clk, rst,
                   (state == S_COMMIT) && res_valid && !res_ready,
                   state == S_COMMIT, "write-back left while result register was held")
  `BPQ_ASSERT_NEXT(a_push_count, clk, rst, fire && (op_kind == OP_PUSH),
                   used == $past(used) + CNT_W'(1), "push did not add one element")
  `BPQ_ASSERT_NOW(a_pop_nonempty, clk, rst, fire && (op_kind == OP_POP),
                  lvl_rd_count != '0, "pop taken from a level with no elements")

endmodule
